>>> src/bsm_pkg.sv
// bsm_pkg: shared types and codes of the bytecode stack machine
`timescale 1ns / 1ps

package bsm_pkg;

  localparam int WORD_W = 32;

  // opcodes
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_SUB      = 8'h02;
  localparam logic [7:0] OP_TOSS     = 8'h08;
  localparam logic [7:0] OP_DUP      = 8'h09;
  localparam logic [7:0] OP_PUSHVAR  = 8'h0C;
  localparam logic [7:0] OP_PUSHBYTE = 8'h0D;
  localparam logic [7:0] OP_PUSHWORD = 8'h0E;
  localparam logic [7:0] OP_PUSH32   = 8'h0F;
  localparam logic [7:0] OP_LIT0     = 8'h10;
  localparam logic [7:0] OP_LIT1     = 8'h11;
  localparam logic [7:0] OP_LIT2     = 8'h12;
  localparam logic [7:0] OP_PRINT    = 8'h81;
  localparam logic [7:0] OP_FACE     = 8'h82;
  localparam logic [7:0] OP_ASK      = 8'h83;
  localparam logic [7:0] OP_PORTRAIT = 8'h84;
  localparam logic [7:0] OP_PARTY    = 8'h85;
  localparam logic [7:0] OP_END      = 8'hFF;

  typedef enum logic [1:0] {
    ACT_EXEC    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_UNDER   = 3'd1,
    STAT_OVER    = 3'd2,
    STAT_ZERO    = 3'd3,
    STAT_IGNORED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_VAR_RD,
    S_RELOAD,
    S_SUM,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              sub;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

endpackage

>>> src/bytecode_stack_machine_unit.sv
// bytecode_stack_machine_unit: byte-coded stack machine with sequenced add/sub unit
`timescale 1ns / 1ps

// Takes one request at a time (action, code_byte, var_index, var_value) and
// answers each with exactly one result: accumulator, top of stack, depth,
// status, halt flag and whether immediate bytes are still expected. A request
// is accepted only while the sequencer is idle. Most requests pass through
// accept, execute and respond on their way to the result register; pushvar on
// its index byte and toss with two or more entries also wait in between on a
// registered read of the variable table or the stack memory. For a variadic
// add or sub with count n, the n entries are popped and the shared add/subtract
// unit folds in one popped stack entry per cycle, streaming from the single read
// port of the stack memory. The result sits in an output register, so the next
// request can be accepted while it waits to be taken. The stack lives in a
// STACK_DEPTH x 32 memory with the top entry cached in a register; the variable
// table is a VARIABLE_COUNT x 32 memory whose entries read as zero until written
// (one valid bit per entry), and needs no clearing pass after reset.
module bytecode_stack_machine_unit import bsm_pkg::*; #(
  parameter int STACK_DEPTH    = 256,
  parameter int VARIABLE_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [7:0]        code_byte,
  input  logic [7:0]        var_index,
  input  logic [31:0]       var_value,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       acc_value,
  output logic [31:0]       top_value,
  output logic [8:0]        depth,
  output logic [2:0]        status,
  output logic              halted,
  output logic              awaiting_immediate
);

  localparam int AW = $clog2(STACK_DEPTH);      // stack memory address
  localparam int CW = $clog2(STACK_DEPTH + 1);  // stack entry count
  localparam int VW = $clog2(VARIABLE_COUNT);   // variable table address

  // latched request
  action_t           a_action;
  logic [7:0]        a_code;
  logic [7:0]        a_index;
  logic [WORD_W-1:0] a_value;

  // machine state
  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] top, top_next;
  logic [7:0]        pending, pending_next;
  logic [2:0]        left, left_next;
  logic [WORD_W-1:0] build, build_next;
  logic              halt, halt_next;
  status_t           st, st_next;

  // add/sub walk
  logic [AW-1:0]     ptr, ptr_next;
  logic [AW-1:0]     base, base_next;
  logic              first, first_next;
  logic              is_sub, is_sub_next;
  logic [WORD_W-1:0] r, r_next;
  logic              var_ok, var_ok_next;

  // stack memory
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic [WORD_W-1:0] stk_wdata;
  logic [AW-1:0]     stk_raddr;
  logic [WORD_W-1:0] stack_rdata;

  // variable table
  logic [WORD_W-1:0] var_mem [VARIABLE_COUNT];
  logic              var_valid [VARIABLE_COUNT];
  logic              var_we;
  logic [WORD_W-1:0] var_rdata;
  logic              var_hit;
  logic              code_in_range, index_in_range;

  logic              push_req;
  logic [WORD_W-1:0] push_val;
  logic              out_load;

  alu_req_t          alu_req;
  logic [WORD_W-1:0] alu_y;

  bsm_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  assign in_ready       = (state == S_IDLE);
  assign code_in_range  = ({1'b0, a_code}  < 9'(VARIABLE_COUNT));
  assign index_in_range = ({1'b0, a_index} < 9'(VARIABLE_COUNT));

  // request latch
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_action <= action_t'(action);
      a_code   <= code_byte;
      a_index  <= var_index;
      a_value  <= var_value;
    end
  end

  // state register and machine registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      acc     <= '0;
      pending <= '0;
      left    <= '0;
      build   <= '0;
      halt    <= 1'b0;
      st      <= STAT_OK;
    end else begin
      state   <= state_next;
      count   <= count_next;
      acc     <= acc_next;
      pending <= pending_next;
      left    <= left_next;
      build   <= build_next;
      halt    <= halt_next;
      st      <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    top    <= top_next;
    ptr    <= ptr_next;
    base   <= base_next;
    first  <= first_next;
    is_sub <= is_sub_next;
    r      <= r_next;
    var_ok <= var_ok_next;
  end

  // stack memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stack_rdata <= stack_mem[stk_raddr];
  end

  // variable table data
  always_ff @(posedge clk) begin
    if (var_we) begin
      var_mem[a_index[VW-1:0]] <= a_value;
    end
    var_rdata <= var_mem[a_code[VW-1:0]];
  end

  // variable table valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VARIABLE_COUNT; i++) begin
        var_valid[i] <= 1'b0;
      end
    end else if (var_we) begin
      var_valid[a_index[VW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    var_hit <= var_valid[a_code[VW-1:0]];
  end

  // sequencer
  always_comb begin
    state_next   = state;
    count_next   = count;
    acc_next     = acc;
    top_next     = top;
    pending_next = pending;
    left_next    = left;
    build_next   = build;
    halt_next    = halt;
    st_next      = st;
    ptr_next     = ptr;
    base_next    = base;
    first_next   = first;
    is_sub_next  = is_sub;
    r_next       = r;
    var_ok_next  = var_ok;
    stk_we       = 1'b0;
    stk_waddr    = AW'(count);
    stk_wdata    = '0;
    stk_raddr    = '0;
    var_we       = 1'b0;
    push_req     = 1'b0;
    push_val     = '0;
    out_load     = 1'b0;
    alu_req.a    = first ? '0 : r;
    alu_req.b    = stack_rdata;
    alu_req.sub  = is_sub && !first;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        st_next    = STAT_OK;
        state_next = S_RESP;
        case (a_action)
          ACT_WRITE: begin
            var_we = index_in_range;
          end
          ACT_RESTART: begin
            count_next   = '0;
            acc_next     = '0;
            pending_next = '0;
            left_next    = '0;
            build_next   = '0;
            halt_next    = 1'b0;
          end
          ACT_EXEC: begin
            if (!halt) begin
              if (left != 3'd0) begin
                // immediate byte, msb first
                build_next = {build[WORD_W-9:0], a_code};
                left_next  = left - 3'd1;
                if (left == 3'd1) begin
                  if (pending == OP_PUSHVAR) begin
                    var_ok_next = code_in_range;
                    state_next  = S_VAR_RD;
                  end else begin
                    push_req = 1'b1;
                    push_val = {build[WORD_W-9:0], a_code};
                  end
                end
              end else begin
                case (a_code)
                  OP_ADD, OP_SUB: begin
                    if (count == '0) begin
                      st_next = STAT_UNDER;
                    end else if (a_code == OP_SUB && top == '0) begin
                      st_next = STAT_ZERO;
                    end else if (top > (32'(count) - 32'd1)) begin
                      st_next = STAT_UNDER;
                    end else if (top == '0) begin
                      // add of nothing replaces the count with zero
                      stk_we    = 1'b1;
                      stk_waddr = AW'(count - CW'(1));
                      stk_wdata = '0;
                      top_next  = '0;
                      acc_next  = '0;
                    end else begin
                      is_sub_next = (a_code == OP_SUB);
                      first_next  = 1'b1;
                      ptr_next    = AW'(count - CW'(2));
                      base_next   = AW'(count - CW'(1) - CW'(top));
                      stk_raddr   = AW'(count - CW'(2));
                      state_next  = S_SUM;
                    end
                  end
                  OP_TOSS: begin
                    if (count == '0) begin
                      st_next = STAT_UNDER;
                    end else begin
                      acc_next   = top;
                      count_next = count - CW'(1);
                      if (count >= CW'(2)) begin
                        stk_raddr  = AW'(count - CW'(2));
                        state_next = S_RELOAD;
                      end
                    end
                  end
                  OP_DUP: begin
                    if (count == '0) begin
                      st_next = STAT_UNDER;
                    end else begin
                      push_req = 1'b1;
                      push_val = top;
                    end
                  end
                  OP_PUSHVAR, OP_PUSHBYTE: begin
                    left_next    = 3'd1;
                    pending_next = a_code;
                    build_next   = '0;
                  end
                  OP_PUSHWORD: begin
                    left_next    = 3'd2;
                    pending_next = a_code;
                    build_next   = '0;
                  end
                  OP_PUSH32: begin
                    left_next    = 3'd4;
                    pending_next = a_code;
                    build_next   = '0;
                  end
                  OP_LIT0, OP_LIT1, OP_LIT2: begin
                    push_req = 1'b1;
                    push_val = 32'(a_code - OP_LIT0);
                  end
                  OP_PRINT, OP_FACE, OP_ASK, OP_PORTRAIT, OP_PARTY: begin
                    st_next = STAT_IGNORED;
                  end
                  OP_END: begin
                    halt_next = 1'b1;
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_VAR_RD: begin
        push_req   = 1'b1;
        push_val   = (var_ok && var_hit) ? var_rdata : '0;
        state_next = S_RESP;
      end

      S_RELOAD: begin
        top_next   = stack_rdata;
        state_next = S_RESP;
      end

      S_SUM: begin
        // fold one popped entry per cycle through the shared unit
        first_next = 1'b0;
        r_next     = alu_y;
        if (ptr == base) begin
          stk_we     = 1'b1;
          stk_waddr  = base;
          stk_wdata  = alu_y;
          top_next   = alu_y;
          acc_next   = alu_y;
          count_next = CW'(base) + CW'(1);
          state_next = S_RESP;
        end else begin
          ptr_next  = ptr - AW'(1);
          stk_raddr = ptr - AW'(1);
        end
      end

      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // common push path with overflow check
    if (push_req) begin
      if (count == CW'(STACK_DEPTH)) begin
        st_next = STAT_OVER;
      end else begin
        stk_we     = 1'b1;
        stk_waddr  = AW'(count);
        stk_wdata  = push_val;
        top_next   = push_val;
        acc_next   = push_val;
        count_next = count + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      acc_value          <= acc;
      top_value          <= (count != '0) ? top : '0;
      depth              <= 9'(count);
      status             <= st;
      halted             <= halt;
      awaiting_immediate <= (left != 3'd0);
    end
  end

endmodule

>>> src/bsm_alu.sv
// bsm_alu: shared 32-bit add/subtract unit of the stack machine
`timescale 1ns / 1ps

module bsm_alu import bsm_pkg::*; (
  input  alu_req_t          req,
  output logic [WORD_W-1:0] y
);

  assign y = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

>>> src/bsm_checker.sv
// bsm_checker: port-level assertions for the stack machine, bound to the top level
`timescale 1ns / 1ps

module bsm_checker import bsm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] acc_value,
  input logic [31:0] top_value,
  input logic [8:0]  depth,
  input logic [2:0]  status,
  input logic        halted,
  input logic        awaiting_immediate
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(acc_value) && $stable(top_value)
      && $stable(depth) && $stable(status))
    else $error("stalled result changed");

  // halt byte is only taken as an opcode
  a_halt_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(halted && awaiting_immediate))
    else $error("halted while awaiting immediate");

  // faults and ignored opcodes only while running and between opcodes
  a_fault_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> !halted && !awaiting_immediate)
    else $error("fault status in wrong machine state");

endmodule

bind bytecode_stack_machine_unit bsm_checker u_bsm_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .acc_value          (acc_value),
  .top_value          (top_value),
  .depth              (depth),
  .status             (status),
  .halted             (halted),
  .awaiting_immediate (awaiting_immediate)
);
